>>> src/kfc_pkg.sv
// kfc_pkg: item types, op codes and port constants of the keyboard FIFO controller
`default_nettype none
package kfc_pkg;

	// op codes of an input item
	localparam logic [2:0] OP_PRESS   = 3'd0;
	localparam logic [2:0] OP_RELEASE = 3'd1;
	localparam logic [2:0] OP_READ    = 3'd2;
	localparam logic [2:0] OP_WRITE   = 3'd3;
	localparam logic [2:0] OP_TICK    = 3'd4;

	// port addresses
	localparam logic [15:0] ADDR_DATA   = 16'h0600;
	localparam logic [15:0] ADDR_STATUS = 16'h0602;
	localparam logic [15:0] ADDR_INT    = 16'h0604;

	// host key indices of the modifiers
	localparam logic [7:0] KEY_CTRL  = 8'h11;
	localparam logic [7:0] KEY_SHIFT = 8'h10;

	// queued byte constants
	localparam logic [7:0] PREFIX_PRESS   = 8'hA0;
	localparam logic [7:0] PREFIX_RELEASE = 8'hB0;
	localparam logic [7:0] PREFIX_CTRL    = 8'h08;
	localparam logic [7:0] PREFIX_SHIFT   = 8'h04;
	localparam logic [7:0] INT_READ_BITS  = 8'hFC;

	typedef struct packed {
		logic [2:0]  op;
		logic [7:0]  host_key;
		logic [7:0]  scan_code;
		logic [15:0] addr;
		logic [7:0]  write_data;
	} in_item_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       irq;
		logic       dropped;
	} out_item_t;

	// control broadcast to every fifo cell
	typedef struct packed {
		logic       pop;
		logic       wr0;
		logic       wr1;
		logic [7:0] byte0;
		logic [7:0] byte1;
	} cell_ctrl_t;

endpackage
`default_nettype wire

>>> src/kfc_cell.sv
// kfc_cell: one byte slot of the shifting key fifo
`default_nettype none
module kfc_cell #(
	parameter int IDX = 0,
	parameter int CW  = 7
) (
	input  wire logic                 clk,
	input  wire kfc_pkg::cell_ctrl_t  ctrl,
	input  wire logic [CW-1:0]        pos0,
	input  wire logic [CW-1:0]        pos1,
	input  wire logic [7:0]           next_data,
	output logic [7:0]                data
);

	logic [7:0] data_q;
	logic [7:0] data_d;

	// shift toward the head on a pop, otherwise take a pushed byte at this slot
	always_comb begin
		data_d = data_q;
		if (ctrl.pop) begin
			data_d = next_data;
		end else if (ctrl.wr0 && pos0 == CW'(IDX)) begin
			data_d = ctrl.byte0;
		end else if (ctrl.wr1 && pos1 == CW'(IDX)) begin
			data_d = ctrl.byte1;
		end
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	assign data = data_q;

endmodule
`default_nettype wire

>>> src/kfc_out_buf.sv
// kfc_out_buf: output register with a skid stage for result items
`default_nettype none
module kfc_out_buf (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire kfc_pkg::out_item_t  push_item,
	output logic                     can_push,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output kfc_pkg::out_item_t       out_item
);

	logic                 out_valid_q;
	logic                 skid_valid_q;
	kfc_pkg::out_item_t   out_item_q;
	kfc_pkg::out_item_t   skid_item_q;
	logic                 out_fire;

	assign out_fire = out_valid_q && out_ready;
	assign can_push = !skid_valid_q;

	// control: output valid and skid valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (push) begin
				if (!out_valid_q || out_fire) begin
					out_valid_q <= 1'b1;
				end else begin
					skid_valid_q <= 1'b1;
				end
			end else if (out_fire) begin
				out_valid_q  <= skid_valid_q;
				skid_valid_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (push) begin
			if (!out_valid_q || out_fire) begin
				out_item_q <= push_item;
			end else begin
				skid_item_q <= push_item;
			end
		end else if (out_fire && skid_valid_q) begin
			out_item_q <= skid_item_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule
`default_nettype wire

>>> src/keyboard_fifo_controller.sv
// keyboard_fifo_controller: top level, port registers, modifier tracking and cell chain
//
// Usage: one input channel (in_valid/in_ready/in_item) carries key events, port reads,
// port writes and frame ticks; one output channel (out_valid/out_ready/out_item) returns
// exactly one result item per input item, in order.
// Results: the result of an accepted item is registered in the output register; one item
// per cycle is sustained while results are taken.
// All work of an item is done in its accept cycle: the key fifo is a row of byte cells
// with the head at cell 0; a pop shifts every cell one place toward the head, and the
// two bytes of a key event are written at slots count and count+1 in the same cycle.
// Stalls: results sit in an output register backed by one skid entry, so one more item
// is taken while a result waits; in_ready falls only when both are full.
// Reset: arst_n clears the byte count, ready bit, latch, interrupt, mask and modifier
// flags; fifo cell contents are not reset and are never read before being written.
// Full fifo: bytes that do not fit are discarded, and dropped is set when either byte of an event is.
`default_nettype none
module keyboard_fifo_controller #(
	parameter int FIFO_DEPTH = 64
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire kfc_pkg::in_item_t   in_item,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output kfc_pkg::out_item_t       out_item
);

	localparam int CW = $clog2(FIFO_DEPTH + 1);

	logic [CW-1:0]       count_q;
	logic [CW-1:0]       count_d;
	logic                data_ready_q;
	logic                data_ready_d;
	logic [7:0]          data_latch_q;
	logic [7:0]          data_latch_d;
	logic                int_pending_q;
	logic                int_pending_d;
	logic [7:0]          int_mask_q;
	logic [7:0]          int_mask_d;
	logic                ctrl_down_q;
	logic                ctrl_down_d;
	logic                shift_down_q;
	logic                shift_down_d;

	logic                in_fire;
	logic                can_push;
	logic                push_ev;
	logic                room0;
	logic                room1;
	logic [7:0]          prefix;
	logic [CW-1:0]       pos1;
	kfc_pkg::cell_ctrl_t cctrl;
	kfc_pkg::out_item_t  res;
	logic [7:0]          cell_data [FIFO_DEPTH];

	assign in_ready = can_push;
	assign in_fire  = in_valid && in_ready;
	assign pos1     = count_q + CW'(1);

	// room for the first and the second byte of a key event
	assign room0 = count_q < CW'(FIFO_DEPTH);
	assign room1 = count_q < CW'(FIFO_DEPTH - 1);

	// step logic for one item
	always_comb begin
		count_d       = count_q;
		data_ready_d  = data_ready_q;
		data_latch_d  = data_latch_q;
		int_pending_d = int_pending_q;
		int_mask_d    = int_mask_q;
		ctrl_down_d   = ctrl_down_q;
		shift_down_d  = shift_down_q;
		push_ev       = 1'b0;
		prefix        = kfc_pkg::PREFIX_RELEASE;
		cctrl         = '0;
		res           = '0;
		unique case (in_item.op)
			kfc_pkg::OP_PRESS, kfc_pkg::OP_RELEASE: begin
				if (in_item.host_key == kfc_pkg::KEY_CTRL) begin
					ctrl_down_d = (in_item.op == kfc_pkg::OP_PRESS);
				end else if (in_item.host_key == kfc_pkg::KEY_SHIFT) begin
					shift_down_d = (in_item.op == kfc_pkg::OP_PRESS);
				end
				if (in_item.op == kfc_pkg::OP_PRESS) begin
					prefix = kfc_pkg::PREFIX_PRESS
						| (ctrl_down_d ? kfc_pkg::PREFIX_CTRL : 8'h00)
						| (shift_down_d ? kfc_pkg::PREFIX_SHIFT : 8'h00);
				end
				push_ev = (in_item.scan_code != 8'h00);
			end
			kfc_pkg::OP_READ: begin
				if (in_item.addr == kfc_pkg::ADDR_DATA) begin
					int_pending_d = 1'b0;
					data_ready_d  = 1'b0;
					res.read_data = data_latch_q;
				end else if (in_item.addr == kfc_pkg::ADDR_STATUS) begin
					res.read_data = {7'd0, data_ready_q};
				end else if (in_item.addr == kfc_pkg::ADDR_INT) begin
					res.read_data = kfc_pkg::INT_READ_BITS | {7'd0, int_pending_q};
				end
			end
			kfc_pkg::OP_WRITE: begin
				if (in_item.addr == kfc_pkg::ADDR_INT) begin
					int_mask_d = in_item.write_data;
				end
			end
			kfc_pkg::OP_TICK: begin
				if (!data_ready_q && count_q != '0) begin
					cctrl.pop    = 1'b1;
					data_ready_d = 1'b1;
					data_latch_d = cell_data[0];
					count_d      = count_q - CW'(1);
				end
				if (data_ready_d && int_mask_q[0]) begin
					int_pending_d = 1'b1;
				end
			end
			default: begin
			end
		endcase
		// the two bytes of a key event, each stored only where there is room
		cctrl.byte0 = prefix;
		cctrl.byte1 = in_item.scan_code;
		cctrl.wr0   = push_ev && room0;
		cctrl.wr1   = push_ev && room1;
		if (push_ev) begin
			count_d = count_q + CW'(cctrl.wr0) + CW'(cctrl.wr1);
		end
		res.dropped = push_ev && !room1;
		res.irq     = int_pending_d;
		// nothing changes unless the item is taken
		if (!in_fire) begin
			cctrl.pop = 1'b0;
			cctrl.wr0 = 1'b0;
			cctrl.wr1 = 1'b0;
		end
	end

	// block state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q       <= '0;
			data_ready_q  <= 1'b0;
			data_latch_q  <= 8'h00;
			int_pending_q <= 1'b0;
			int_mask_q    <= 8'h00;
			ctrl_down_q   <= 1'b0;
			shift_down_q  <= 1'b0;
		end else if (in_fire) begin
			count_q       <= count_d;
			data_ready_q  <= data_ready_d;
			data_latch_q  <= data_latch_d;
			int_pending_q <= int_pending_d;
			int_mask_q    <= int_mask_d;
			ctrl_down_q   <= ctrl_down_d;
			shift_down_q  <= shift_down_d;
		end
	end

	// chain of fifo cells, head at cell 0
	for (genvar i = 0; i < FIFO_DEPTH; i++) begin : g_cell
		logic [7:0] nxt;
		if (i == FIFO_DEPTH - 1) begin : g_last
			assign nxt = 8'h00;
		end else begin : g_mid
			assign nxt = cell_data[i+1];
		end
		kfc_cell #(
			.IDX (i),
			.CW  (CW)
		) u_cell (
			.clk       (clk),
			.ctrl      (cctrl),
			.pos0      (count_q),
			.pos1      (pos1),
			.next_data (nxt),
			.data      (cell_data[i])
		);
	end

	// result register and skid entry
	kfc_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_fire),
		.push_item (res),
		.can_push  (can_push),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	// checks
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(FIFO_DEPTH))
		else $error("fifo byte count above depth");

	a_int_needs_ready: assert property (@(posedge clk) disable iff (!arst_n)
		int_pending_q |-> data_ready_q)
		else $error("interrupt pending without ready data");

	a_pop_sets_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cctrl.pop |=> data_ready_q && count_q == $past(count_q) - CW'(1))
		else $error("pop did not load the latch");

	a_data_read_clears: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && in_item.op == kfc_pkg::OP_READ && in_item.addr == kfc_pkg::ADDR_DATA
		|=> !data_ready_q && !int_pending_q)
		else $error("data port read left ready or interrupt set");

endmodule
`default_nettype wire

>>> tb/sv/kfc_checker.sv
// kfc_checker: channel monitor, predictor and result comparison for the keyboard FIFO controller
`timescale 1ns / 1ps
module kfc_checker #(
	parameter int FIFO_DEPTH = 64
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic               in_ready,
	input  wire kfc_pkg::in_item_t  in_item,
	input  wire logic               out_valid,
	input  wire logic               out_ready,
	input  wire kfc_pkg::out_item_t out_item,
	output int                      fail_count,
	output int                      results_due
);

	localparam int MAX_PRINTED = 100;

	// predicted controller state
	logic [7:0] key_bytes [FIFO_DEPTH];
	int         head_ptr;
	int         tail_ptr;
	int         byte_count;
	logic       ready_flag;
	logic [7:0] latch_byte;
	logic       int_flag;
	logic [7:0] mask_byte;
	logic       ctrl_held;
	logic       shift_held;

	// results predicted but not yet seen on the output channel
	kfc_pkg::out_item_t kbd_results_due [$];

	task automatic report_mismatch(input string what, input int got, input int want);
		if (fail_count < MAX_PRINTED)
			$display("%0t: mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
		fail_count++;
	endtask

	// store one byte unless the fifo is full; returns 1 on a drop
	function automatic logic queue_key_byte(input logic [7:0] b);
		if (byte_count >= FIFO_DEPTH)
			return 1'b1;
		key_bytes[tail_ptr] = b;
		tail_ptr = (tail_ptr + 1) % FIFO_DEPTH;
		byte_count++;
		return 1'b0;
	endfunction

	function automatic void track_modifier(input logic [7:0] key, input logic level);
		if (key == kfc_pkg::KEY_CTRL)
			ctrl_held = level;
		else if (key == kfc_pkg::KEY_SHIFT)
			shift_held = level;
	endfunction

	// work out the result of one item and advance the predicted state
	function automatic kfc_pkg::out_item_t predict_kbd_step(input kfc_pkg::in_item_t it);
		kfc_pkg::out_item_t r;
		logic               drop;
		logic [7:0]         prefix;
		r    = '0;
		drop = 1'b0;
		case (it.op)
			kfc_pkg::OP_PRESS: begin
				track_modifier(it.host_key, 1'b1);
				if (it.scan_code != 8'h00) begin
					prefix = kfc_pkg::PREFIX_PRESS
						| (ctrl_held ? kfc_pkg::PREFIX_CTRL : 8'h00)
						| (shift_held ? kfc_pkg::PREFIX_SHIFT : 8'h00);
					drop |= queue_key_byte(prefix);
					drop |= queue_key_byte(it.scan_code);
				end
			end
			kfc_pkg::OP_RELEASE: begin
				track_modifier(it.host_key, 1'b0);
				if (it.scan_code != 8'h00) begin
					drop |= queue_key_byte(kfc_pkg::PREFIX_RELEASE);
					drop |= queue_key_byte(it.scan_code);
				end
			end
			kfc_pkg::OP_READ: begin
				if (it.addr == kfc_pkg::ADDR_DATA) begin
					int_flag    = 1'b0;
					ready_flag  = 1'b0;
					r.read_data = latch_byte;
				end else if (it.addr == kfc_pkg::ADDR_STATUS) begin
					r.read_data = {7'b0, ready_flag};
				end else if (it.addr == kfc_pkg::ADDR_INT) begin
					r.read_data = kfc_pkg::INT_READ_BITS | {7'b0, int_flag};
				end
			end
			kfc_pkg::OP_WRITE: begin
				if (it.addr == kfc_pkg::ADDR_INT)
					mask_byte = it.write_data;
			end
			kfc_pkg::OP_TICK: begin
				// latch the oldest byte when the latch is free
				if (!ready_flag && byte_count > 0) begin
					ready_flag = 1'b1;
					latch_byte = key_bytes[head_ptr];
					head_ptr   = (head_ptr + 1) % FIFO_DEPTH;
					byte_count--;
				end
				if (ready_flag && mask_byte[0] && !int_flag)
					int_flag = 1'b1;
			end
			default: begin
			end
		endcase
		r.irq     = int_flag;
		r.dropped = drop;
		return r;
	endfunction

	// watch both channels at the rising edge
	always @(posedge clk or negedge arst_n) begin : watch
		kfc_pkg::out_item_t want;
		if (!arst_n) begin
			head_ptr   = 0;
			tail_ptr   = 0;
			byte_count = 0;
			ready_flag = 1'b0;
			latch_byte = 8'h00;
			int_flag   = 1'b0;
			mask_byte  = 8'h00;
			ctrl_held  = 1'b0;
			shift_held = 1'b0;
			kbd_results_due.delete();
		end else begin
			if (in_valid && in_ready)
				kbd_results_due.push_back(predict_kbd_step(in_item));
			if (out_valid && out_ready) begin
				if (kbd_results_due.size() == 0) begin
					report_mismatch("unexpected result", int'(out_item), 0);
				end else begin
					want = kbd_results_due.pop_front();
					if (out_item.read_data !== want.read_data)
						report_mismatch("read_data", int'(out_item.read_data),
							int'(want.read_data));
					if (out_item.irq !== want.irq)
						report_mismatch("irq", int'(out_item.irq), int'(want.irq));
					if (out_item.dropped !== want.dropped)
						report_mismatch("dropped", int'(out_item.dropped),
							int'(want.dropped));
				end
			end
		end
		results_due = kbd_results_due.size();
	end

endmodule

>>> tb/sv/tb_keyboard_fifo_controller.sv
// tb_keyboard_fifo_controller: stimulus, clock, reset and verdict for the keyboard FIFO controller
`timescale 1ns / 1ps
module tb_keyboard_fifo_controller;

	localparam int          FIFO_DEPTH     = 64;
	localparam int          PHASE_ITEMS    = 50;
	localparam int          PHASE_COUNT    = 9;
	localparam int          CALM_PHASES    = 2;
	localparam int          DRAIN_CYCLES   = 10;
	localparam logic [2:0]  OP_SPARE_FIRST = 3'd5;
	localparam logic [2:0]  OP_SPARE_LAST  = 3'd7;

	typedef enum int {MIX_ALL, MIX_FLOOD, MIX_DRAIN} stim_mix_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	kfc_pkg::in_item_t  in_item;
	logic               out_valid;
	logic               out_ready;
	kfc_pkg::out_item_t out_item;
	int                 fail_count;
	int                 results_due;
	bit                 calm;

	keyboard_fifo_controller #(.FIFO_DEPTH(FIFO_DEPTH)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	kfc_checker #(.FIFO_DEPTH(FIFO_DEPTH)) u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_item     (in_item),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_item    (out_item),
		.fail_count  (fail_count),
		.results_due (results_due)
	);

	// clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// run limit
	initial begin
		#2000000;
		$display("Test completed with failures");
		$finish;
	end

	// receiver stalls in random bursts
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (!calm && $urandom_range(0, 4) == 0) begin
				out_ready = 1'b0;
				repeat ($urandom_range(1, 7)) @(negedge clk);
			end
			out_ready = 1'b1;
		end
	end

	function automatic kfc_pkg::in_item_t make_item(input logic [2:0] op,
			input logic [7:0] key, input logic [7:0] code, input logic [15:0] addr,
			input logic [7:0] wdata);
		kfc_pkg::in_item_t it;
		it.op         = op;
		it.host_key   = key;
		it.scan_code  = code;
		it.addr       = addr;
		it.write_data = wdata;
		return it;
	endfunction

	// pick a port address, mostly a decoded one
	function automatic logic [15:0] pick_port();
		int p;
		p = $urandom_range(0, 9);
		if (p < 3)
			return kfc_pkg::ADDR_DATA;
		else if (p < 5)
			return kfc_pkg::ADDR_STATUS;
		else if (p < 8)
			return kfc_pkg::ADDR_INT;
		return 16'($urandom_range(0, 16'hFFFF));
	endfunction

	// random item shaped by the current mix
	function automatic kfc_pkg::in_item_t random_item(input stim_mix_t mix);
		kfc_pkg::in_item_t it;
		int                w;
		it.host_key   = ($urandom_range(0, 9) < 4)
			? (($urandom_range(0, 1) == 1) ? kfc_pkg::KEY_CTRL : kfc_pkg::KEY_SHIFT)
			: 8'($urandom_range(0, 255));
		it.scan_code  = ($urandom_range(0, 9) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
		it.addr       = 16'($urandom_range(0, 16'hFFFF));
		it.write_data = 8'($urandom_range(0, 255));
		w = $urandom_range(0, 99);
		case (mix)
			MIX_FLOOD: it.op = (w < 60) ? kfc_pkg::OP_PRESS
				: (w < 95) ? kfc_pkg::OP_RELEASE : kfc_pkg::OP_TICK;
			MIX_DRAIN: it.op = (w < 45) ? kfc_pkg::OP_TICK
				: (w < 92) ? kfc_pkg::OP_READ : kfc_pkg::OP_WRITE;
			default: begin
				if (w < 25)
					it.op = kfc_pkg::OP_PRESS;
				else if (w < 45)
					it.op = kfc_pkg::OP_RELEASE;
				else if (w < 70)
					it.op = kfc_pkg::OP_READ;
				else if (w < 80)
					it.op = kfc_pkg::OP_WRITE;
				else if (w < 95)
					it.op = kfc_pkg::OP_TICK;
				else
					it.op = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
			end
		endcase
		if (it.op == kfc_pkg::OP_READ || it.op == kfc_pkg::OP_WRITE)
			it.addr = pick_port();
		// drain phases mostly empty the latch so ticks keep popping
		if (mix == MIX_DRAIN && it.op == kfc_pkg::OP_READ && $urandom_range(0, 3) != 0)
			it.addr = kfc_pkg::ADDR_DATA;
		return it;
	endfunction

	// offer one item, hold it until taken, then maybe leave a gap
	task automatic send_item(input kfc_pkg::in_item_t it);
		in_item  = it;
		in_valid = 1'b1;
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 7)) @(negedge clk);
		end
	endtask

	// hold the sender until every predicted result has come back
	task automatic wait_results_back();
		in_valid = 1'b0;
		while (results_due != 0)
			@(negedge clk);
	endtask

	initial begin : stimulus
		kfc_pkg::in_item_t directed [$];
		stim_mix_t         mix;
		arst_n   = 1'b0;
		in_valid = 1'b0;
		in_item  = '0;
		calm     = 1'b0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reads at reset, mask and dead writes, modifiers, zero codes, spare ops
		directed.push_back(make_item(kfc_pkg::OP_READ, 8'h00, 8'h00,
			kfc_pkg::ADDR_STATUS, 8'h00));
		directed.push_back(make_item(kfc_pkg::OP_READ, 8'h00, 8'h00,
			kfc_pkg::ADDR_INT, 8'h00));
		directed.push_back(make_item(kfc_pkg::OP_READ, 8'h00, 8'h00,
			kfc_pkg::ADDR_DATA, 8'h00));
		directed.push_back(make_item(kfc_pkg::OP_TICK, 8'h00, 8'h00, 16'h0000, 8'h00));
		directed.push_back(make_item(kfc_pkg::OP_WRITE, 8'h00, 8'h00,
			kfc_pkg::ADDR_INT, 8'h01));
		directed.push_back(make_item(kfc_pkg::OP_WRITE, 8'h00, 8'h00,
			kfc_pkg::ADDR_DATA, 8'hFF));
		directed.push_back(make_item(kfc_pkg::OP_WRITE, 8'h00, 8'h00,
			kfc_pkg::ADDR_STATUS, 8'hAA));
		directed.push_back(make_item(kfc_pkg::OP_WRITE, 8'h00, 8'h00, 16'hFFFF, 8'h55));
		directed.push_back(make_item(kfc_pkg::OP_PRESS, kfc_pkg::KEY_CTRL, 8'h00,
			16'h0000, 8'h00));
		directed.push_back(make_item(kfc_pkg::OP_PRESS, kfc_pkg::KEY_SHIFT, 8'h2A,
			16'h0000, 8'h00));
		directed.push_back(make_item(kfc_pkg::OP_PRESS, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF));
		directed.push_back(make_item(kfc_pkg::OP_RELEASE, kfc_pkg::KEY_SHIFT, 8'h00,
			16'h0000, 8'h00));
		directed.push_back(make_item(kfc_pkg::OP_RELEASE, kfc_pkg::KEY_CTRL, 8'h1D,
			16'h0000, 8'h00));
		directed.push_back(make_item(kfc_pkg::OP_RELEASE, 8'h00, 8'h01, 16'h0000, 8'h00));
		directed.push_back(make_item(kfc_pkg::OP_TICK, 8'h00, 8'h00, 16'h0000, 8'h00));
		directed.push_back(make_item(kfc_pkg::OP_READ, 8'h00, 8'h00,
			kfc_pkg::ADDR_INT, 8'h00));
		directed.push_back(make_item(kfc_pkg::OP_READ, 8'h00, 8'h00,
			kfc_pkg::ADDR_STATUS, 8'h00));
		directed.push_back(make_item(kfc_pkg::OP_READ, 8'h00, 8'h00,
			kfc_pkg::ADDR_DATA, 8'h00));
		directed.push_back(make_item(kfc_pkg::OP_TICK, 8'h00, 8'h00, 16'h0000, 8'h00));
		directed.push_back(make_item(kfc_pkg::OP_READ, 8'h00, 8'h00, 16'hFFFF, 8'h00));
		directed.push_back(make_item(kfc_pkg::OP_READ, 8'h00, 8'h00, 16'h0000, 8'h00));
		for (int op = OP_SPARE_FIRST; op <= OP_SPARE_LAST; op++)
			directed.push_back(make_item(3'(op), kfc_pkg::KEY_CTRL, 8'h55,
				kfc_pkg::ADDR_INT, 8'hFF));
		directed.push_back(make_item(kfc_pkg::OP_WRITE, 8'h00, 8'h00,
			kfc_pkg::ADDR_INT, 8'h00));
		foreach (directed[i])
			send_item(directed[i]);
		wait_results_back();

		// random phases: floods fill the fifo, drains empty it through the latch
		for (int phase = 0; phase < PHASE_COUNT; phase++) begin
			case (phase % 3)
				0: mix = MIX_ALL;
				1: mix = MIX_FLOOD;
				default: mix = MIX_DRAIN;
			endcase
			calm = (phase >= PHASE_COUNT - CALM_PHASES);
			if (phase == PHASE_COUNT / 2)
				wait_results_back();
			for (int n = 0; n < PHASE_ITEMS; n++)
				send_item(random_item(mix));
		end
		in_valid = 1'b0;

		// let the last results drain
		while (results_due != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

>>> files.f
src/kfc_pkg.sv
src/kfc_cell.sv
src/kfc_out_buf.sv
src/keyboard_fifo_controller.sv
tb/sv/kfc_checker.sv
tb/sv/tb_keyboard_fifo_controller.sv
